// ----- rtl/core/hsv_pkg.sv -----
// Shared types and constants for the HSV to RGB converter.
// No dependencies; used by every file under rtl/core.
package hsv_pkg;

  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned LATENCY    = 4 + DIV_STAGES;
  localparam int unsigned NUM_W      = 30;
  localparam int unsigned DEN_W      = 22;
  localparam int unsigned SEL_W      = 14;
  localparam int unsigned PROD_W     = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam logic [7:0]  FULL_RESET = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_SAT_FULL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_FULL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_FULL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_FULL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_FULL  = 3'd4;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ----- rtl/core/hsv_div.sv -----
// Pipelined restoring divider, three numerators over one shared divisor.
// Depends on hsv_pkg; quotients are known to fit in 8 bits.
module hsv_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [hsv_pkg::NUM_W-1:0]     num [3],
  input  logic [hsv_pkg::DEN_W-1:0]     den,
  output logic                          out_valid,
  output logic [7:0]                    quo [3]
);

  localparam int unsigned N = hsv_pkg::DIV_STAGES;

  logic                      vld [N+1];
  logic [hsv_pkg::NUM_W-1:0] rem [N+1][3];
  logic [hsv_pkg::DEN_W-1:0] dd  [N+1];
  logic [7:0]                q   [N+1][3];

  assign vld[0] = in_valid;
  assign dd[0]  = den;
  for (genvar c = 0; c < 3; c++) begin : g_in
    assign rem[0][c] = num[c];
    assign q[0][c]   = 8'd0;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int unsigned SH = N - 1 - i;
    logic [hsv_pkg::NUM_W:0] dsh;
    assign dsh = {{(hsv_pkg::NUM_W + 1 - hsv_pkg::DEN_W){1'b0}}, dd[i]} << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      dd[i+1] <= dd[i];
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic take;
      assign take = {1'b0, rem[i][c]} >= dsh;
      always_ff @(posedge clk) begin
        rem[i+1][c] <= take ? rem[i][c] - dsh[hsv_pkg::NUM_W-1:0] : rem[i][c];
        q[i+1][c]   <= q[i][c] | (take ? (8'd1 << SH) : 8'd0);
      end
    end
  end

  assign out_valid = vld[N];
  for (genvar c = 0; c < 3; c++) begin : g_out
    assign quo[c] = q[N][c];
  end

endmodule

// ----- rtl/core/hsv_to_rgb_converter_top.sv -----
// HSV to RGB converter top level: configuration registers, front stages
// and the shared divider. Depends on hsv_pkg and hsv_div.
//
// Takes one pixel word per clock when start is high; busy is always low, so
// a word is never refused. Each result appears on rgb for exactly one cycle
// with done high, after four front stages (clamp and sector split, term
// numerators, two multiply stages) and eight divider stages, one quotient
// bit each. The receiver cannot stall, and none is needed. Configuration
// writes are always ready; write the full-scale registers only while no
// pixel is in flight.
module hsv_to_rgb_converter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  hsv_pkg::hsv_t                     hsv,
  output logic                              done,
  output hsv_pkg::rgb_t                     rgb,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_data
);

  logic [7:0] sat_full, val_full, red_full, green_full, blue_full;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes drop the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_full   <= hsv_pkg::FULL_RESET;
      val_full   <= hsv_pkg::FULL_RESET;
      red_full   <= hsv_pkg::FULL_RESET;
      green_full <= hsv_pkg::FULL_RESET;
      blue_full  <= hsv_pkg::FULL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hsv_pkg::REG_SAT_FULL:   sat_full   <= cfg_data;
        hsv_pkg::REG_VAL_FULL:   val_full   <= cfg_data;
        hsv_pkg::REG_RED_FULL:   red_full   <= cfg_data;
        hsv_pkg::REG_GREEN_FULL: green_full <= cfg_data;
        hsv_pkg::REG_BLUE_FULL:  blue_full  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: clamp, split hue into sector and remainder of 60.
  logic [3:0] q60;
  logic [2:0] sector_next;
  logic [5:0] m_next;
  logic [8:0] base60;

  always_comb begin
    q60 = 4'd0;
    for (int j = 1; j <= 8; j++) begin
      if (hsv.hue >= 9'(60 * j)) q60 = 4'(j);
    end
    sector_next = (q60 >= 4'd6) ? 3'(q60 - 4'd6) : q60[2:0];
    base60      = 9'(q60 * 6'd60);
    m_next      = 6'(hsv.hue - base60);
  end

  logic       v1;
  logic [2:0] sector1;
  logic [5:0] m1;
  logic [7:0] s1, val1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
  end

  always_ff @(posedge clk) begin
    sector1 <= sector_next;
    m1      <= m_next;
    s1      <= (hsv.sat > sat_full) ? sat_full : hsv.sat;
    val1    <= (hsv.val > val_full) ? val_full : hsv.val;
  end

  // Stage 2: numerators of p, q, t and v over 60*S; pick by sector.
  logic [hsv_pkg::SEL_W-1:0] nv, np, nq, nt;
  logic [hsv_pkg::SEL_W-1:0] sel_next [3];
  logic                      gray1, zero1;

  always_comb begin
    nv    = hsv_pkg::SEL_W'(sat_full * 6'd60);
    np    = hsv_pkg::SEL_W'((sat_full - s1) * 6'd60);
    nq    = nv - hsv_pkg::SEL_W'(s1 * m1);
    nt    = nv - hsv_pkg::SEL_W'(s1 * (6'd60 - m1));
    gray1 = (s1 == 8'd0);
    zero1 = (val1 == 8'd0);
    unique case (sector1)
      3'd0:    begin sel_next[0] = nv; sel_next[1] = nt; sel_next[2] = np; end
      3'd1:    begin sel_next[0] = nq; sel_next[1] = nv; sel_next[2] = np; end
      3'd2:    begin sel_next[0] = np; sel_next[1] = nv; sel_next[2] = nt; end
      3'd3:    begin sel_next[0] = np; sel_next[1] = nq; sel_next[2] = nv; end
      3'd4:    begin sel_next[0] = nt; sel_next[1] = np; sel_next[2] = nv; end
      default: begin sel_next[0] = nv; sel_next[1] = np; sel_next[2] = nq; end
    endcase
    // Gray: plain v*full/val_full.
    if (gray1) begin
      for (int k = 0; k < 3; k++) sel_next[k] = hsv_pkg::SEL_W'(1);
    end
  end

  logic                      v2, gray2, zero2;
  logic [hsv_pkg::SEL_W-1:0] sel2 [3];
  logic [hsv_pkg::SEL_W-1:0] den60_2;
  logic [7:0]                val2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) sel2[k] <= sel_next[k];
    den60_2 <= nv;
    val2    <= val1;
    gray2   <= gray1;
    zero2   <= zero1;
  end

  // Stage 3: v * numerator, and the full divisor.
  logic                       v3;
  logic [hsv_pkg::PROD_W-1:0] prod3 [3];
  logic [hsv_pkg::DEN_W-1:0]  den3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod3[k] <= zero2 ? '0 : hsv_pkg::PROD_W'(val2 * sel2[k]);
    end
    // A zero pixel gets divisor one so the quotient stays zero.
    if (zero2)      den3 <= hsv_pkg::DEN_W'(1);
    else if (gray2) den3 <= hsv_pkg::DEN_W'(val_full);
    else            den3 <= hsv_pkg::DEN_W'(den60_2 * val_full);
  end

  // Stage 4: scale by each channel's full scale.
  logic                      v4;
  logic [hsv_pkg::NUM_W-1:0] num4 [3];
  logic [hsv_pkg::DEN_W-1:0] den4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    num4[0] <= hsv_pkg::NUM_W'(prod3[0] * red_full);
    num4[1] <= hsv_pkg::NUM_W'(prod3[1] * green_full);
    num4[2] <= hsv_pkg::NUM_W'(prod3[2] * blue_full);
    den4    <= den3;
  end

  // Stages 5 to 12: one quotient bit per stage.
  logic [7:0] quo [3];

  hsv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .num       (num4),
    .den       (den4),
    .out_valid (done),
    .quo       (quo)
  );

  assign rgb.red   = quo[0];
  assign rgb.green = quo[1];
  assign rgb.blue  = quo[2];

endmodule

// ----- rtl/core/hsv_checker.sv -----
// Port-level checker for the HSV to RGB converter, with its bind.
// Depends on hsv_pkg and hsv_to_rgb_converter_top.
module hsv_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input hsv_pkg::hsv_t hsv,
  input logic          done,
  input hsv_pkg::rgb_t rgb,
  input logic          cfg_ready
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy && cfg_ready)
    else $error("converter refused a word");

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, hsv_pkg::LATENCY))
    else $error("result without a matching start");

  a_black: assert property (@(posedge clk) disable iff (rst)
    done && $past(start && hsv.val == 8'd0, hsv_pkg::LATENCY) |-> rgb == '0)
    else $error("zero value gave a non-black pixel");

endmodule

bind hsv_to_rgb_converter_top hsv_checker u_hsv_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .hsv       (hsv),
  .done      (done),
  .rgb       (rgb),
  .cfg_ready (cfg_ready)
);

// ----- sim/hsv_to_rgb_converter_checker.sv -----
// Checker for the HSV to RGB converter: watches the pixel, result and register
// channels, predicts each colour word and compares. Depends on hsv_pkg.
module hsv_to_rgb_converter_checker
  import hsv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  hsv_t                 hsv,
  input  logic                 done,
  input  rgb_t                 rgb,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] sat_fs, val_fs, red_fs, green_fs, blue_fs;
  rgb_t colour_q[$];

  function automatic logic [7:0] scale(longint v, longint num, longint den, longint fs);
    return 8'((v * num * fs) / (den * longint'(val_fs)));
  endfunction

  function automatic rgb_t hsv_colour(hsv_t px);
    longint s, v, sf, m, np, nq, nt, nv, r, g, b;
    int sector;
    rgb_t c;
    s = px.sat; v = px.val; sf = sat_fs;
    if (s > sf) s = sf;
    if (v > val_fs) v = val_fs;
    if (val_fs == 0 || v == 0) return '0;
    if (s == 0) begin
      c.red = scale(v, 1, 1, red_fs);
      c.green = scale(v, 1, 1, green_fs);
      c.blue = scale(v, 1, 1, blue_fs);
      return c;
    end
    sector = (px.hue / 60) % 6;
    m = px.hue % 60;
    np = 60 * (sf - s);
    nq = 60 * sf - s * m;
    nt = 60 * sf - s * (60 - m);
    nv = 60 * sf;
    case (sector)
      0: begin r = nv; g = nt; b = np; end
      1: begin r = nq; g = nv; b = np; end
      2: begin r = np; g = nv; b = nt; end
      3: begin r = np; g = nq; b = nv; end
      4: begin r = nt; g = np; b = nv; end
      default: begin r = nv; g = np; b = nq; end
    endcase
    c.red = scale(v, r, nv, red_fs);
    c.green = scale(v, g, nv, green_fs);
    c.blue = scale(v, b, nv, blue_fs);
    return c;
  endfunction

  always @(posedge clk) begin
    rgb_t exp_c;
    if (rst) begin
      errors <= 0;
      pending <= 0;
      colour_q.delete();
      {sat_fs, val_fs, red_fs, green_fs, blue_fs} <= {5{FULL_RESET}};
    end else begin
      if (done) begin
        if (colour_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result %h", $time, rgb);
        end else begin
          exp_c = colour_q.pop_front();
          if (exp_c.red !== rgb.red || exp_c.green !== rgb.green
              || exp_c.blue !== rgb.blue) begin
            errors <= errors + 1;
            $display("%0t: mismatch expected %h actual %h", $time, exp_c, rgb);
          end
        end
      end
      if (start && !busy) colour_q.push_back(hsv_colour(hsv));
      pending <= colour_q.size();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAT_FULL:   sat_fs <= cfg_data;
          REG_VAL_FULL:   val_fs <= cfg_data;
          REG_RED_FULL:   red_fs <= cfg_data;
          REG_GREEN_FULL: green_fs <= cfg_data;
          REG_BLUE_FULL:  blue_fs <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- sim/hsv_to_rgb_converter_top_test.sv -----
// Test top for the HSV to RGB converter: drives pixel words and register
// writes, and gives the verdict. Depends on hsv_pkg, the converter top and the checker.
module hsv_to_rgb_converter_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hsv_pkg::*;

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  hsv_t hsv;
  rgb_t rgb;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;
  int errors, pending;

  hsv_to_rgb_converter_top uut (.*);
  hsv_to_rgb_converter_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Write one register; hold valid until ready is seen at a rising edge.
  // Valid stays high for a following write; the caller drops it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Present one pixel word after a random gap; advance once it is taken.
  // Start stays high for a back-to-back word; a gap or the drain drops it.
  task automatic send_pixel(hsv_t px);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1; hsv <= px;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drain: wait for all expected words, then let the pipe settle.
  task automatic drain();
    int guard;
    guard = 0;
    start <= 0;
    while (pending != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_scales(logic [7:0] s, logic [7:0] v, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b);
    write_reg(REG_SAT_FULL, s);
    write_reg(REG_VAL_FULL, v);
    write_reg(REG_RED_FULL, r);
    write_reg(REG_GREEN_FULL, g);
    write_reg(REG_BLUE_FULL, b);
    cfg_valid <= 0;
  endtask

  function automatic hsv_t rand_pixel();
    hsv_t px;
    // Mostly legal hues, sometimes the wrap range up to 511.
    px.hue = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                         : 9'($urandom_range(0, 359));
    px.sat = 8'($urandom);
    px.val = 8'($urandom);
    return px;
  endfunction

  initial begin
    hsv_t px;
    start = 0; hsv = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    rst = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: sector edges, gray, black, extremes, hue wrap.
    for (int h = 0; h < 360; h += 60) begin
      send_pixel('{hue: 9'(h), sat: 8'd255, val: 8'd255});
      send_pixel('{hue: 9'(h + 59), sat: 8'd128, val: 8'd200});
    end
    send_pixel('{hue: 9'd100, sat: 8'd0, val: 8'd255});
    send_pixel('{hue: 9'd200, sat: 8'd255, val: 8'd0});
    send_pixel('{hue: 9'd359, sat: 8'd1, val: 8'd1});
    send_pixel('{hue: 9'd511, sat: 8'd255, val: 8'd255});
    send_pixel('{hue: 9'd360, sat: 8'd170, val: 8'd85});
    drain();

    // Clamping and zero full scales, then random settings with extremes.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_scales(8'd100, 8'd50, 8'd255, 8'd1, 8'd128);
        1: set_scales(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        2: set_scales(8'd255, 8'd0, 8'd255, 8'd255, 8'd255);
        3: set_scales(8'd1, 8'd1, 8'd0, 8'd255, 8'd0);
        4: set_scales(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        default: set_scales(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                            8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                            8'($urandom_range(1, 255)));
      endcase
      for (int n = 0; n < 200; n++) begin
        px = rand_pixel();
        send_pixel(px);
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
